// ===== sv/pct_pkg.sv =====
// pct_pkg: sizes, item kind codes and the saturating helper for the perceptron trainer.
// Standalone; imported by perceptron_trainer.
`timescale 1ns / 1ps
`default_nettype none

package pct_pkg;

   // Array and field sizes
   localparam int NUM_INPUTS  = 5;
   localparam int WEIGHT_BITS = 24;
   localparam int LOAD_W      = 24;
   localparam int RATE_W      = 12;
   localparam int KIND_W      = 2;
   localparam int SEL_W       = $clog2(NUM_INPUTS + 1);
   localparam int ACC_W       = WEIGHT_BITS + $clog2(NUM_INPUTS + 1);
   localparam int SAT_W       = ((WEIGHT_BITS > LOAD_W) ? WEIGHT_BITS : LOAD_W) + 2;
   localparam int CSR_DATA_W  = 32;
   localparam int CSR_ADDR_W  = 3;

   localparam logic [RATE_W-1:0] RATE_RESET = RATE_W'(205);

   // Register index of the step size
   localparam logic [CSR_ADDR_W-3:0] REG_RATE = '0;

   typedef enum logic [KIND_W-1:0] {
      KIND_TRAIN = 2'd0,
      KIND_CHECK = 2'd1,
      KIND_LOAD  = 2'd2
   } kind_type;

   typedef logic signed [WEIGHT_BITS-1:0] weight_type;
   typedef logic signed [SAT_W-1:0]       wide_type;

   // Clamp a widened value into the signed weight range
   function automatic weight_type sat_weight(input wide_type v);
      wide_type hi;
      wide_type lo;
      hi = {{(SAT_W - WEIGHT_BITS + 1){1'b0}}, {(WEIGHT_BITS - 1){1'b1}}};
      lo = ~hi;
      if (v > hi) begin
         return hi[WEIGHT_BITS-1:0];
      end else if (v < lo) begin
         return lo[WEIGHT_BITS-1:0];
      end
      return v[WEIGHT_BITS-1:0];
   endfunction

endpackage

`default_nettype wire

// ===== sv/perceptron_trainer.sv =====
// Perceptron trainer: one weight per input bit plus a threshold, with train, check and load items.
// Depends on pct_pkg for sizes, kind codes and weight saturation.
//
// Accepts one item every clock cycle while req_stall is low. The item is captured
// in an input register at the accepting edge. While the item is held there, the
// weighted sum, the sign test and the saturating weight/threshold update happen
// in one step. When it leaves the input register, the result register and the
// weight registers load together, and the result is presented from the result
// register. An item sees every update made by the item before it. A stall on the
// result side backs up through the input register into req_stall. The step size
// lives in a single register at byte address 0. Write it only while no item is in
// flight.
`timescale 1ns / 1ps
`default_nettype none

module perceptron_trainer (
   input  wire                                  clock,
   input  wire                                  reset,
   // Item input
   input  wire                                  req_valid,
   output logic                                 req_stall,
   input  wire  [pct_pkg::KIND_W-1:0]           req_kind,
   input  wire  [pct_pkg::NUM_INPUTS-1:0]       req_pattern,
   input  wire                                  req_target,
   input  wire  [pct_pkg::SEL_W-1:0]            req_load_select,
   input  wire  signed [pct_pkg::LOAD_W-1:0]    req_load_value,
   // Result output
   output logic                                 rsp_valid,
   input  wire                                  rsp_stall,
   output logic                                 rsp_prediction,
   output logic                                 rsp_matches_res,
   // Register port
   input  wire                                  psel,
   input  wire                                  penable,
   input  wire                                  pwrite,
   input  wire  [pct_pkg::CSR_ADDR_W-1:0]       paddr,
   input  wire  [pct_pkg::CSR_DATA_W-1:0]       pwdata,
   output logic [pct_pkg::CSR_DATA_W-1:0]       prdata,
   output logic                                 pready
);
   import pct_pkg::*;

   // Step size register
   logic [RATE_W-1:0] rate_ff;
   logic              csr_wr;

   // Input register
   logic                  s_valid_ff;
   logic [KIND_W-1:0]     s_kind_ff;
   logic [NUM_INPUTS-1:0] s_pattern_ff;
   logic                  s_target_ff;
   logic [SEL_W-1:0]      s_sel_ff;
   logic signed [LOAD_W-1:0] s_value_ff;

   // Model state
   weight_type w_ff [NUM_INPUTS];
   weight_type w_in [NUM_INPUTS];
   weight_type thresh_ff;
   weight_type thresh_in;

   // Result register
   logic rsp_valid_ff;
   logic pred_ff;
   logic match_ff;

   // Datapath
   logic                    out_ready;
   logic                    s_fire;
   logic                    in_fire;
   logic signed [ACC_W-1:0] acc;
   logic                    pred_bit;
   logic                    match_bit;
   logic                    res_pred;
   logic                    res_match;
   wide_type                step;
   wide_type                load_wide;

   // Register port
   assign pready = 1'b1;
   assign csr_wr = psel && penable && pwrite && pready
                   && (paddr[CSR_ADDR_W-1:2] == REG_RATE);
   assign prdata = (paddr[CSR_ADDR_W-1:2] == REG_RATE)
                   ? CSR_DATA_W'(rate_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         rate_ff <= RATE_RESET;
      end else if (csr_wr) begin
         rate_ff <= pwdata[RATE_W-1:0];
      end
   end

   // Handshake: the input stage moves when the result register is free
   assign out_ready = !rsp_valid_ff || !rsp_stall;
   assign s_fire    = s_valid_ff && out_ready;
   assign req_stall = s_valid_ff && !out_ready;
   assign in_fire   = req_valid && !req_stall;

   // Weighted sum minus threshold; weight j goes with pattern bit N-1-j
   always_comb begin
      acc = -ACC_W'(thresh_ff);
      for (int j = 0; j < NUM_INPUTS; j++) begin
         if (s_pattern_ff[NUM_INPUTS-1-j]) begin
            acc = acc + ACC_W'(w_ff[j]);
         end
      end
   end

   assign pred_bit  = !acc[ACC_W-1];
   assign match_bit = (pred_bit == s_target_ff);

   // Twice the rate, positive when the target is +1
   always_comb begin
      step = SAT_W'({1'b0, rate_ff, 1'b0});
      if (!s_target_ff) begin
         step = -step;
      end
   end

   assign load_wide = SAT_W'(s_value_ff);

   // Next weights, threshold and result fields
   always_comb begin
      for (int j = 0; j < NUM_INPUTS; j++) begin
         w_in[j] = w_ff[j];
      end
      thresh_in = thresh_ff;
      res_pred  = 1'b0;
      res_match = 1'b0;
      case (s_kind_ff)
         KIND_TRAIN: begin
            res_pred  = pred_bit;
            res_match = match_bit;
            if (!match_bit) begin
               for (int j = 0; j < NUM_INPUTS; j++) begin
                  if (s_pattern_ff[NUM_INPUTS-1-j]) begin
                     w_in[j] = sat_weight(SAT_W'(w_ff[j]) + step);
                  end
               end
               thresh_in = sat_weight(SAT_W'(thresh_ff) - step);
            end
         end
         KIND_CHECK: begin
            res_pred  = pred_bit;
            res_match = match_bit;
         end
         KIND_LOAD: begin
            for (int j = 0; j < NUM_INPUTS; j++) begin
               if (s_sel_ff == SEL_W'(j)) begin
                  w_in[j] = sat_weight(load_wide);
               end
            end
            if (s_sel_ff == SEL_W'(NUM_INPUTS)) begin
               thresh_in = sat_weight(load_wide);
            end
         end
         default: begin
            // unused kind: no state change, zero result
         end
      endcase
   end

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         s_valid_ff <= 1'b0;
      end else if (in_fire) begin
         s_valid_ff <= 1'b1;
      end else if (s_fire) begin
         s_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (in_fire) begin
         s_kind_ff    <= req_kind;
         s_pattern_ff <= req_pattern;
         s_target_ff  <= req_target;
         s_sel_ff     <= req_load_select;
         s_value_ff   <= req_load_value;
      end
   end

   // Weights and threshold update as the item leaves the input register
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int j = 0; j < NUM_INPUTS; j++) begin
            w_ff[j] <= '0;
         end
         thresh_ff <= '0;
      end else if (s_fire) begin
         for (int j = 0; j < NUM_INPUTS; j++) begin
            w_ff[j] <= w_in[j];
         end
         thresh_ff <= thresh_in;
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_ready) begin
         rsp_valid_ff <= s_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s_fire) begin
         pred_ff  <= res_pred;
         match_ff <= res_match;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_prediction  = pred_ff;
   assign rsp_matches_res = match_ff;

   // Checks
   a_stall_needs_item: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> s_valid_ff)
      else $error("input stalled with no item held");

   a_load_zero_result: assert property (@(posedge clock) disable iff (reset)
      (s_fire && (s_kind_ff == KIND_LOAD)) |=>
         (rsp_valid && !rsp_prediction && !rsp_matches_res))
      else $error("load item gave a nonzero result");

   a_check_keeps_thresh: assert property (@(posedge clock) disable iff (reset)
      (s_fire && (s_kind_ff == KIND_CHECK)) |=> $stable(thresh_ff))
      else $error("check item changed the threshold");

   a_false_pos_raises: assert property (@(posedge clock) disable iff (reset)
      (s_fire && (s_kind_ff == KIND_TRAIN) && pred_bit && !s_target_ff) |=>
         (thresh_ff >= $past(thresh_ff)))
      else $error("threshold dropped after a false positive");

   a_false_neg_lowers: assert property (@(posedge clock) disable iff (reset)
      (s_fire && (s_kind_ff == KIND_TRAIN) && !pred_bit && s_target_ff) |=>
         (thresh_ff <= $past(thresh_ff)))
      else $error("threshold rose after a false negative");

endmodule

`default_nettype wire
